// ===== sv/wsfd_pkg.sv =====
// Shared types and constants of the WebSocket frame decoder.
// Holds the parser phase, result kinds, error codes, the result record and the
// bit layout of the result tdata word. No dependencies.
package wsfd_pkg;

   // Parser phase
   typedef enum logic [2:0] {
      PH_FIRST   = 3'd0,
      PH_SECOND  = 3'd1,
      PH_EXTLEN  = 3'd2,
      PH_MASK    = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_CLOSE   = 3'd5,
      PH_SKIP    = 3'd6
   } phase_type;

   // Result kind, carried on tuser
   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_DATA   = 2'd1,
      KIND_CLOSE  = 2'd2,
      KIND_ERROR  = 2'd3
   } kind_type;

   // Error codes of an error result
   typedef enum logic [1:0] {
      ERR_OPCODE    = 2'd0,
      ERR_CONTROL   = 2'd1,
      ERR_CLOSE_LEN = 2'd2
   } err_type;

   // Opcodes that the decoder accepts
   localparam logic [3:0] OP_CONT  = 4'h0;
   localparam logic [3:0] OP_TEXT  = 4'h1;
   localparam logic [3:0] OP_BIN   = 4'h2;
   localparam logic [3:0] OP_CLOSE = 4'h8;
   localparam logic [3:0] OP_PING  = 4'h9;
   localparam logic [3:0] OP_PONG  = 4'hA;

   // Header constants
   localparam logic [6:0]  LEN7_EXT16     = 7'd126;
   localparam logic [6:0]  LEN7_EXT64     = 7'd127;
   localparam int unsigned CTRL_MAX_LEN   = 125;
   localparam logic [15:0] CLOSE_DEFAULT  = 16'd1000;
   localparam int unsigned FLAG_FIN       = 0;
   localparam int unsigned FLAG_MASKED    = 4;

   // Result record as it leaves the parser
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data_byte;
      logic [3:0]  opcode;
      logic [4:0]  flags;
      logic [63:0] payload_length;
      logic [3:0]  header_length;
      logic [15:0] close_code;
      err_type     error_code;
      logic        last;
   } result_type;

   // Layout of rsp_tdata, lowest field first
   localparam int unsigned RSP_TDATA_W   = 104;
   localparam int unsigned RSP_DATA_LSB  = 0;
   localparam int unsigned RSP_OP_LSB    = 8;
   localparam int unsigned RSP_FLAGS_LSB = 12;
   localparam int unsigned RSP_LEN_LSB   = 17;
   localparam int unsigned RSP_HLEN_LSB  = 81;
   localparam int unsigned RSP_CODE_LSB  = 85;
   localparam int unsigned RSP_ERR_LSB   = 101;

endpackage

// ===== sv/wsfd_parse.sv =====
// Frame parser: phase register, header registers and the per-byte decode and
// unmask logic. Produces at most one result record per byte. Uses wsfd_pkg.
module wsfd_parse #(
   parameter int LENGTH_BITS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           in_byte,
   output logic                 res_valid,
   output wsfd_pkg::result_type res
);
   import wsfd_pkg::*;

   phase_type              phase_ff, phase_in;
   logic [3:0]             hdr_cnt_ff, hdr_cnt_in;
   logic [3:0]             hdr_total_ff, hdr_total_in;
   logic [3:0]             opcode_ff, opcode_in;
   logic [4:0]             flags_ff, flags_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in;
   logic [LENGTH_BITS-1:0] remain_ff, remain_in;
   logic [31:0]            key_ff, key_in;
   logic [1:0]             key_idx_ff, key_idx_in;
   logic [15:0]            close_hold_ff, close_hold_in;

   logic [6:0]             l7;
   logic                   masked_b;
   logic                   sec_ext;
   logic [3:0]             ext_bytes;
   logic [LENGTH_BITS-1:0] ext_len;
   logic [3:0]             cnt_inc;
   logic [3:0]             ext_end;
   logic                   ext_done;
   logic                   mask_done;
   logic                   finish;
   logic [LENGTH_BITS-1:0] fin_len;
   logic [4:0]             fin_flags;
   logic [3:0]             fin_hlen;
   logic                   op_valid;
   logic                   fin_err;
   err_type                fin_code;
   phase_type              fin_phase;
   logic [LENGTH_BITS-1:0] remain_dec;
   logic                   remain_last;
   logic [7:0]             key_byte;
   logic [7:0]             plain;

   // Shared decode of the current byte against the stored header state
   always_comb begin
      l7        = in_byte[6:0];
      masked_b  = in_byte[7];
      sec_ext   = (l7 == LEN7_EXT16) || (l7 == LEN7_EXT64);
      ext_bytes = (l7 == LEN7_EXT16) ? 4'd2 : ((l7 == LEN7_EXT64) ? 4'd8 : 4'd0);

      // Extended length shifts in big-endian and saturates when it overflows
      if (len_ff[LENGTH_BITS-1 -: 8] != 8'd0) begin
         ext_len = '1;
      end else begin
         ext_len = {len_ff[LENGTH_BITS-9:0], in_byte};
      end

      cnt_inc   = hdr_cnt_ff + 4'd1;
      ext_end   = hdr_total_ff - (flags_ff[FLAG_MASKED] ? 4'd4 : 4'd0);
      ext_done  = !(cnt_inc < ext_end);
      mask_done = !(cnt_inc < hdr_total_ff);

      // The header completes on this byte
      finish = ((phase_ff == PH_SECOND) && !sec_ext && !masked_b)
            || ((phase_ff == PH_EXTLEN) && ext_done && !flags_ff[FLAG_MASKED])
            || ((phase_ff == PH_MASK) && mask_done);

      fin_len   = len_ff;
      fin_flags = flags_ff;
      fin_hlen  = hdr_total_ff;
      if (phase_ff == PH_SECOND) begin
         fin_len   = LENGTH_BITS'(l7);
         fin_flags = flags_ff | {masked_b, 4'b0000};
         fin_hlen  = 4'd2;
      end else if (phase_ff == PH_EXTLEN) begin
         fin_len = ext_len;
      end

      // Frame acceptance checks, in order of precedence
      op_valid = (opcode_ff == OP_CONT) || (opcode_ff == OP_TEXT) || (opcode_ff == OP_BIN)
              || (opcode_ff == OP_CLOSE) || (opcode_ff == OP_PING)
              || (opcode_ff == OP_PONG);
      fin_err  = 1'b1;
      fin_code = ERR_OPCODE;
      priority if (!op_valid) begin
         fin_code = ERR_OPCODE;
      end else if (opcode_ff[3]
                   && (!fin_flags[FLAG_FIN] || (fin_len > LENGTH_BITS'(CTRL_MAX_LEN)))) begin
         fin_code = ERR_CONTROL;
      end else if ((opcode_ff == OP_CLOSE) && (fin_len == LENGTH_BITS'(1))) begin
         fin_code = ERR_CLOSE_LEN;
      end else begin
         fin_err = 1'b0;
      end

      if (fin_err) begin
         fin_phase = (fin_len != '0) ? PH_SKIP : PH_FIRST;
      end else if (fin_len == '0) begin
         fin_phase = PH_FIRST;
      end else begin
         fin_phase = (opcode_ff == OP_CLOSE) ? PH_CLOSE : PH_PAYLOAD;
      end

      remain_dec  = remain_ff - LENGTH_BITS'(1);
      remain_last = (remain_dec == '0);
      key_byte    = key_ff[(5'd24 - {key_idx_ff, 3'b000}) +: 8];
      plain       = in_byte ^ key_byte;
   end

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_FIRST: begin
            phase_in = PH_SECOND;
         end
         PH_SECOND: begin
            if (sec_ext) begin
               phase_in = PH_EXTLEN;
            end else if (masked_b) begin
               phase_in = PH_MASK;
            end else begin
               phase_in = fin_phase;
            end
         end
         PH_EXTLEN: begin
            if (!ext_done) begin
               phase_in = PH_EXTLEN;
            end else if (flags_ff[FLAG_MASKED]) begin
               phase_in = PH_MASK;
            end else begin
               phase_in = fin_phase;
            end
         end
         PH_MASK: begin
            phase_in = mask_done ? fin_phase : PH_MASK;
         end
         PH_PAYLOAD: begin
            phase_in = remain_last ? PH_FIRST : PH_PAYLOAD;
         end
         PH_CLOSE: begin
            if (key_idx_ff == 2'd0) begin
               phase_in = PH_CLOSE;
            end else begin
               phase_in = remain_last ? PH_FIRST : PH_PAYLOAD;
            end
         end
         PH_SKIP: begin
            phase_in = remain_last ? PH_FIRST : PH_SKIP;
         end
         default: begin
            phase_in = PH_FIRST;
         end
      endcase
   end

   // Register updates and the result record
   always_comb begin
      hdr_cnt_in     = hdr_cnt_ff;
      hdr_total_in   = hdr_total_ff;
      opcode_in      = opcode_ff;
      flags_in       = flags_ff;
      len_in         = len_ff;
      remain_in      = remain_ff;
      key_in         = key_ff;
      key_idx_in     = key_idx_ff;
      close_hold_in  = close_hold_ff;

      res_valid          = 1'b0;
      res.kind           = KIND_HEADER;
      res.data_byte      = 8'd0;
      res.opcode         = opcode_ff;
      res.flags          = fin_flags;
      res.payload_length = 64'(fin_len);
      res.header_length  = 4'd0;
      res.close_code     = 16'd0;
      res.error_code     = ERR_OPCODE;
      res.last           = 1'b0;

      unique case (phase_ff)
         PH_FIRST: begin
            opcode_in  = in_byte[3:0];
            flags_in   = {1'b0, in_byte[4], in_byte[5], in_byte[6], in_byte[7]};
            hdr_cnt_in = 4'd1;
         end
         PH_SECOND: begin
            flags_in     = fin_flags;
            hdr_cnt_in   = 4'd2;
            key_in       = 32'd0;
            len_in       = sec_ext ? '0 : LENGTH_BITS'(l7);
            hdr_total_in = 4'd2 + ext_bytes + (masked_b ? 4'd4 : 4'd0);
         end
         PH_EXTLEN: begin
            len_in     = ext_len;
            hdr_cnt_in = cnt_inc;
         end
         PH_MASK: begin
            key_in     = {key_ff[23:0], in_byte};
            hdr_cnt_in = cnt_inc;
         end
         PH_PAYLOAD: begin
            key_idx_in    = key_idx_ff + 2'd1;
            remain_in     = remain_dec;
            res_valid     = 1'b1;
            res.kind      = KIND_DATA;
            res.data_byte = plain;
            res.last      = remain_last;
         end
         PH_CLOSE: begin
            key_idx_in = key_idx_ff + 2'd1;
            remain_in  = remain_dec;
            if (key_idx_ff == 2'd0) begin
               close_hold_in = {plain, 8'h00};
            end else begin
               close_hold_in  = close_hold_ff | {8'h00, plain};
               res_valid      = 1'b1;
               res.kind       = KIND_CLOSE;
               res.close_code = close_hold_ff | {8'h00, plain};
               res.last       = remain_last;
            end
         end
         PH_SKIP: begin
            remain_in = remain_dec;
         end
         default: begin
            remain_in = remain_ff;
         end
      endcase

      // Header complete: header or error result, payload count loaded
      if (finish) begin
         key_idx_in        = 2'd0;
         remain_in         = fin_len;
         res_valid         = 1'b1;
         res.header_length = fin_hlen;
         if (fin_err) begin
            res.kind       = KIND_ERROR;
            res.error_code = fin_code;
            res.last       = 1'b1;
         end else begin
            res.kind = KIND_HEADER;
            res.last = (fin_len == '0);
            if ((fin_len == '0) && (opcode_ff == OP_CLOSE)) begin
               res.close_code = CLOSE_DEFAULT;
            end
         end
      end
   end

   // Phase register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FIRST;
      end else if (step) begin
         phase_ff <= phase_in;
      end
   end

   // Header and payload state; each field is written before it is read
   always_ff @(posedge clock) begin
      if (step) begin
         hdr_cnt_ff    <= hdr_cnt_in;
         hdr_total_ff  <= hdr_total_in;
         opcode_ff     <= opcode_in;
         flags_ff      <= flags_in;
         len_ff        <= len_in;
         remain_ff     <= remain_in;
         key_ff        <= key_in;
         key_idx_ff    <= key_idx_in;
         close_hold_ff <= close_hold_in;
      end
   end

endmodule

// ===== sv/wsfd_out_stage.sv =====
// Result register of the frame decoder: holds one result record until the
// downstream transfer and packs it onto the stream ports. Uses wsfd_pkg.
module wsfd_out_stage (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  load,
   input  wsfd_pkg::result_type                  load_data,
   input  logic                                  rsp_tready,
   output logic                                  rsp_tvalid,
   output logic [wsfd_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   output logic [1:0]                            rsp_tuser,
   output logic                                  rsp_tlast
);
   import wsfd_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   // Valid flag: set on load, cleared once the result is taken
   always_comb begin
      priority if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   // Pack the record, lowest field first, padded to whole bytes
   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = data_ff.kind;
   assign rsp_tlast  = data_ff.last;
   assign rsp_tdata  = {1'b0, data_ff.error_code, data_ff.close_code,
                        data_ff.header_length, data_ff.payload_length,
                        data_ff.flags, data_ff.opcode, data_ff.data_byte};

endmodule

// ===== sv/websocket_frame_decoder.sv =====
// WebSocket frame decoder, one frame stream byte per transfer.
// A result is presented on rsp after its input transfer passes the input
// register and is decoded into the result register. Throughput: one byte per
// cycle; only a stalled rsp side holds off input. Reset is synchronous and
// active high: it clears the valid flags and returns the parser to the first
// header byte.
module websocket_frame_decoder #(
   parameter int LENGTH_BITS = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // req_tdata: [7:0] in_byte
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [7:0]                            req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // rsp_tdata: [7:0] data_byte, [11:8] opcode, [16:12] flags,
   // [80:17] payload_length, [84:81] header_length, [100:85] close_code,
   // [102:101] error_code, [103] zero
   output logic [wsfd_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   // rsp_tuser: [1:0] kind
   output logic [1:0]                            rsp_tuser,
   output logic                                  rsp_tlast
);
   import wsfd_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       step;
   logic       res_valid;
   result_type res;

   // A byte is decoded when the result register is free or being emptied
   assign step       = in_valid_ff && (!rsp_tvalid || rsp_tready);
   assign req_tready = !in_valid_ff || step;

   // Input register
   always_comb begin
      priority if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
   end

   wsfd_parse #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .in_byte   (in_byte_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   wsfd_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (step && res_valid),
      .load_data  (res),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // An error result always ends its frame
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == KIND_ERROR)) |-> rsp_tlast)
      else $error("error result without last");

   // A header result ends the frame exactly when the payload is empty
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == KIND_HEADER))
      |-> (rsp_tlast == (rsp_tdata[RSP_LEN_LSB +: 64] == 64'd0)))
      else $error("header last does not match empty payload");

   // Payload and close-code results carry no header length or error code
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && ((rsp_tuser == KIND_DATA) || (rsp_tuser == KIND_CLOSE)))
      |-> ((rsp_tdata[RSP_HLEN_LSB +: 4] == 4'd0) && (rsp_tdata[RSP_ERR_LSB +: 2] == 2'd0)))
      else $error("payload result carries header fields");

   // Input is never refused while the input register is empty
   assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_tready)
      else $error("input stalled with empty input register");

endmodule
